// ----- design/lcdlt_pkg.sv -----
// Package: item types, state record, mode codes and timing defaults for the LCD line timing unit.
`timescale 1ns / 1ps
package lcdlt_pkg;

    localparam int LINE_CYCLES_DEF     = 456;
    localparam int VISIBLE_LINES_DEF   = 144;
    localparam int LAST_LINE_DEF       = 153;
    localparam int OAM_CYCLES_DEF      = 80;
    localparam int TRANSFER_CYCLES_DEF = 172;

    localparam int CNT_W  = 9;
    localparam int LINE_W = 8;

    localparam logic [1:0] MODE_HBLANK   = 2'd0;
    localparam logic [1:0] MODE_VBLANK   = 2'd1;
    localparam logic [1:0] MODE_OAM      = 2'd2;
    localparam logic [1:0] MODE_TRANSFER = 2'd3;

    typedef struct packed {
        logic [7:0] elapsed_cycles;
        logic       lcd_enable;
        logic [7:0] compare_line;
        logic       hblank_irq_enable;
        logic       vblank_mode_irq_enable;
        logic       oam_irq_enable;
        logic       match_irq_enable;
    } lcdlt_in_t;

    typedef struct packed {
        logic [7:0] current_line;
        logic [1:0] lcd_mode;
        logic       line_match;
        logic       vblank_irq;
        logic       status_irq;
        logic       render_line_strobe;
    } lcdlt_out_t;

    typedef struct packed {
        logic [CNT_W-1:0]  line_counter;
        logic [LINE_W-1:0] line;
        logic [1:0]        mode_bits;
        logic              match_flag;
        logic [LINE_W-1:0] last_seen_line;
        logic [LINE_W-1:0] last_seen_compare;
    } lcdlt_state_t;

endpackage

// ----- design/lcd_line_timing_and_status_unit.sv -----
// Top level: input register, timing core and result register of the LCD line timing unit.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_data (lcdlt_in_t)
//  m_        out        m_valid/m_ready    m_data (lcdlt_out_t)
//
// One beat per cycle sustained while m_ready is high; a beat passes the input register, then the result register.
// The timing state updates as a beat moves from the input register to the result register.
// aresetn is synchronous, active low; it clears both stages and loads the line timing state.
// A stall on m_ready holds the result; the input register still takes one more beat.
`timescale 1ns / 1ps
module lcd_line_timing_and_status_unit
    import lcdlt_pkg::*;
#(
    parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int LAST_LINE       = LAST_LINE_DEF,
    parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lcdlt_in_t  s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output lcdlt_out_t m_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    lcdlt_in_t  in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    lcdlt_out_t out_data_reg;
    lcdlt_out_t step_res;
    logic       advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    lcdlt_timing #(
        .LINE_CYCLES    (LINE_CYCLES),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .LAST_LINE      (LAST_LINE),
        .OAM_CYCLES     (OAM_CYCLES),
        .TRANSFER_CYCLES(TRANSFER_CYCLES)
    ) u_timing (
        .aclk   (aclk),
        .aresetn(aresetn),
        .step_en(advance),
        .item   (in_data_reg),
        .res    (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_vblank_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.vblank_irq |-> m_data.current_line == 8'(VISIBLE_LINES))
        else $error("vblank pulse off the first blank line");

    a_render_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.render_line_strobe |-> m_data.current_line < 8'(VISIBLE_LINES)
            && !m_data.vblank_irq)
        else $error("render strobe outside visible lines");

    // a held input beat is never dropped while the result side stalls
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input beat lost during stall");

endmodule

// ----- design/lcdlt_step.sv -----
// Combinational step: park on disable, mode classification, compare refresh, countdown and line advance.
`timescale 1ns / 1ps
module lcdlt_step
    import lcdlt_pkg::*;
#(
    parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int LAST_LINE       = LAST_LINE_DEF,
    parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF
) (
    input  lcdlt_state_t st,
    input  lcdlt_in_t    item,
    output lcdlt_state_t st_next,
    output lcdlt_out_t   res
);

    localparam int OAM_BOUND  = LINE_CYCLES - OAM_CYCLES;
    localparam int XFER_BOUND = OAM_BOUND - TRANSFER_CYCLES;
    localparam logic signed [10:0] OAM_BOUND_S  = 11'(OAM_BOUND);
    localparam logic signed [10:0] XFER_BOUND_S = 11'(XFER_BOUND);
    localparam logic [CNT_W-1:0]   RELOAD       = CNT_W'(LINE_CYCLES);
    localparam logic [LINE_W-1:0]  VIS_L        = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0]  LAST_L       = LINE_W'(LAST_LINE);

    always_comb begin
        logic signed [10:0] cnt_s;
        logic [1:0]         mode;
        logic               want;
        logic               stat;
        logic               vbl;
        logic               rnd;
        logic [9:0]         diff;
        logic [LINE_W-1:0]  ln;

        st_next = st;
        cnt_s   = signed'({2'b00, st.line_counter});
        mode    = MODE_HBLANK;
        want    = 1'b0;
        stat    = 1'b0;
        vbl     = 1'b0;
        rnd     = 1'b0;
        diff    = {1'b0, st.line_counter} - {2'b00, item.elapsed_cycles};
        ln      = st.line;

        if (!item.lcd_enable) begin
            st_next.line_counter = RELOAD;
            st_next.line         = '0;
            st_next.mode_bits    = MODE_VBLANK;
        end else begin
            if (st.line >= VIS_L) begin
                mode = MODE_VBLANK;
                want = item.vblank_mode_irq_enable;
            end else if (cnt_s >= OAM_BOUND_S) begin
                mode = MODE_OAM;
                want = item.oam_irq_enable;
            end else if (cnt_s >= XFER_BOUND_S) begin
                mode = MODE_TRANSFER;
            end else begin
                mode = MODE_HBLANK;
                want = item.hblank_irq_enable;
            end
            stat = want && (mode != st.mode_bits);

            // compare flag only refreshes when line or compare moved
            if (st.line != st.last_seen_line || item.compare_line != st.last_seen_compare) begin
                st_next.match_flag        = (st.line == item.compare_line);
                st_next.last_seen_line    = st.line;
                st_next.last_seen_compare = item.compare_line;
                if (st.line == item.compare_line && item.match_irq_enable) begin
                    stat = 1'b1;
                end
            end
            st_next.mode_bits = mode;

            if (ln > LAST_L) begin
                ln = '0;
            end
            st_next.line_counter = diff[CNT_W-1:0];
            if (diff[9] || diff == '0) begin
                ln = ln + 1'b1;
                st_next.line_counter = RELOAD;
                if (ln == VIS_L) begin
                    vbl = 1'b1;
                end else if (ln > LAST_L) begin
                    ln = '0;
                end else if (ln < VIS_L) begin
                    rnd = 1'b1;
                end
            end
            st_next.line = ln;
        end

        res.current_line       = st_next.line;
        res.lcd_mode           = st_next.mode_bits;
        res.line_match         = st_next.match_flag;
        res.vblank_irq         = vbl;
        res.status_irq         = stat;
        res.render_line_strobe = rnd;
    end

endmodule

// ----- design/lcdlt_timing.sv -----
// Timing state registers, updated once per beat taken from the input register.
`timescale 1ns / 1ps
module lcdlt_timing
    import lcdlt_pkg::*;
#(
    parameter int LINE_CYCLES     = LINE_CYCLES_DEF,
    parameter int VISIBLE_LINES   = VISIBLE_LINES_DEF,
    parameter int LAST_LINE       = LAST_LINE_DEF,
    parameter int OAM_CYCLES      = OAM_CYCLES_DEF,
    parameter int TRANSFER_CYCLES = TRANSFER_CYCLES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  lcdlt_in_t  item,
    output lcdlt_out_t res
);

    lcdlt_state_t state_reg;
    lcdlt_state_t state_next;

    lcdlt_step #(
        .LINE_CYCLES    (LINE_CYCLES),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .LAST_LINE      (LAST_LINE),
        .OAM_CYCLES     (OAM_CYCLES),
        .TRANSFER_CYCLES(TRANSFER_CYCLES)
    ) u_step (
        .st     (state_reg),
        .item   (item),
        .st_next(state_next),
        .res    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.line_counter      <= CNT_W'(LINE_CYCLES);
            state_reg.line              <= '0;
            state_reg.mode_bits         <= MODE_HBLANK;
            state_reg.match_flag        <= 1'b0;
            state_reg.last_seen_line    <= '0;
            state_reg.last_seen_compare <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    // line never rests beyond the last line while running
    a_line_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> state_reg.line <= LINE_W'(LAST_LINE))
        else $error("line above last line");

    // disabled beat parks timing at line 0 in vblank with a full counter
    a_disable_park: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && !item.lcd_enable |=> state_reg.line == '0
            && state_reg.mode_bits == MODE_VBLANK
            && state_reg.line_counter == CNT_W'(LINE_CYCLES))
        else $error("disable did not park timing");

    // counter never stored as zero
    a_cnt_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line_counter != '0)
        else $error("line counter reached zero");

endmodule
